FILE: rtl/core/hsa_pkg.sv
// shared types and codes for the handle slot allocator
`timescale 1ns / 1ps

package hsa_pkg;

   // fixed field widths of the request and response beats
   localparam int ACTION_W = 2;
   localparam int KEY_W    = 32;
   localparam int SID_W    = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // request action codes
   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD   = 2'd0,
      ACT_ERASE = 2'd1,
      ACT_GET   = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_PRESENT = 2'd1,
      ST_FULL    = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   // one response beat as produced by the slot table
   typedef struct packed {
      logic [SID_W-1:0]   result_id;
      logic [KEY_W-1:0]   result_key;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } result_type;

endpackage

FILE: rtl/core/hsa_slot_table.sv
// slot table: key match array, occupancy bits, free id stack and slot count
`timescale 1ns / 1ps

module hsa_slot_table #(
   parameter int SLOTS    = 64,
   parameter int KEY_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         exec,
   input  hsa_pkg::action_type          action,
   input  logic [KEY_BITS-1:0]          key,
   input  logic [hsa_pkg::SID_W-1:0]    sid,
   output hsa_pkg::result_type          result
);

   localparam int ID_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   // table state
   logic [KEY_BITS-1:0] key_ff [SLOTS];
   logic [SLOTS-1:0]    occ_ff;
   logic [ID_W-1:0]     stack_ff [SLOTS];
   logic [CNT_W-1:0]    used_ff;
   // highest count seen since reset; stack entries below SLOTS - peak are
   // still untouched and never read (a pop then takes count + 1 as the new top), so no clearing pass is needed
   logic [CNT_W-1:0]    peak_ff;
   // id on top of the free stack, kept in a register
   logic [ID_W-1:0]     top_ff;

   logic [SLOTS-1:0]    hit_vec;
   logic                hit;
   logic [ID_W-1:0]     hit_id;
   logic                in_range;
   logic [ID_W-1:0]     sidx;
   logic                slot_busy;
   logic                full;
   logic [ID_W-1:0]     push_idx;
   logic [ID_W-1:0]     pop_id;
   logic                next_fresh;
   logic [ID_W-1:0]     next_idx;
   logic                do_pop;
   logic                do_free;

   // parallel key match against every occupied slot
   always_comb begin
      hit_id = '0;
      for (int i = 0; i < SLOTS; i++) begin
         hit_vec[i] = occ_ff[i] && (key_ff[i] == key);
         if (hit_vec[i]) begin
            hit_id = hit_id | ID_W'(i);
         end
      end
   end

   assign hit = |hit_vec;

   // slot lookup and free stack pointers
   assign in_range  = (32'(sid) < SLOTS);
   assign sidx      = ID_W'(sid);
   assign slot_busy = in_range && occ_ff[sidx];
   assign full      = (used_ff == CNT_W'(SLOTS));
   assign push_idx  = ID_W'(SLOTS - 32'(used_ff));
   assign pop_id    = top_ff;

   // entry that becomes the top after a pop; for an untouched entry the id is taken from the count
   assign next_fresh = (32'(used_ff) + 1 >= 32'(peak_ff));
   assign next_idx   = ID_W'(SLOTS - 2 - 32'(used_ff));

   // action decode and response
   always_comb begin
      result.result_id  = sid;
      result.result_key = '0;
      result.status     = hsa_pkg::ST_OK;
      result.count      = hsa_pkg::COUNT_W'(used_ff);
      do_pop            = 1'b0;
      do_free           = 1'b0;
      unique case (action)
         hsa_pkg::ACT_ADD: begin
            if (hit) begin
               result.result_id = hsa_pkg::SID_W'(hit_id);
               result.status    = hsa_pkg::ST_PRESENT;
            end else if (full) begin
               result.result_id = '0;
               result.status    = hsa_pkg::ST_FULL;
            end else begin
               result.result_id = hsa_pkg::SID_W'(pop_id);
               result.count     = hsa_pkg::COUNT_W'(used_ff + 1'b1);
               do_pop           = 1'b1;
            end
         end
         hsa_pkg::ACT_ERASE: begin
            if (!slot_busy) begin
               result.status = hsa_pkg::ST_EMPTY;
            end else begin
               result.count = hsa_pkg::COUNT_W'(used_ff - 1'b1);
               do_free      = 1'b1;
            end
         end
         hsa_pkg::ACT_GET: begin
            if (!slot_busy) begin
               result.status = hsa_pkg::ST_EMPTY;
            end else begin
               result.result_key = hsa_pkg::KEY_W'(key_ff[sidx]);
            end
         end
         default: begin
         end
      endcase
   end

   // key storage, written on allocation only
   always_ff @(posedge clock) begin
      if (exec && do_pop) begin
         key_ff[pop_id] <= key;
      end
   end

   // free stack memory: push writes one entry, pop reads the next top
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
      end else if (exec) begin
         if (do_free) begin
            stack_ff[push_idx] <= sidx;
            top_ff             <= sidx;
         end else if (do_pop) begin
            if (next_fresh) begin
               top_ff <= ID_W'(used_ff + 1'b1);
            end else begin
               top_ff <= stack_ff[next_idx];
            end
         end
      end
   end

   // occupancy, count and peak count
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= '0;
         used_ff <= '0;
         peak_ff <= '0;
      end else if (exec) begin
         if (do_pop) begin
            occ_ff[pop_id] <= 1'b1;
            used_ff        <= used_ff + 1'b1;
            if (used_ff == peak_ff) begin
               peak_ff <= peak_ff + 1'b1;
            end
         end
         if (do_free) begin
            occ_ff[sidx] <= 1'b0;
            used_ff      <= used_ff - 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   a_count_matches_occ: assert property (@(posedge clock) disable iff (reset)
      $countones(occ_ff) == 32'(used_ff))
      else $error("slot count differs from occupied slots");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= SLOTS)
      else $error("slot count above table size");

   a_pop_marks_slot: assert property (@(posedge clock) disable iff (reset)
      exec && do_pop |=> occ_ff[$past(pop_id)] && key_ff[$past(pop_id)] == $past(key))
      else $error("allocated slot not filled");

   a_free_clears_slot: assert property (@(posedge clock) disable iff (reset)
      exec && do_free |=> !occ_ff[$past(sidx)] && used_ff == $past(used_ff) - 1'b1)
      else $error("erased slot still occupied");

   a_add_no_duplicate: assert property (@(posedge clock) disable iff (reset)
      exec && action == hsa_pkg::ACT_ADD |-> $countones(hit_vec) <= 1)
      else $error("key stored in more than one slot");
`endif

endmodule

FILE: rtl/core/handle_slot_allocator_top.sv
// top level of the handle slot allocator: request and response registers
`timescale 1ns / 1ps

// Handle slot allocator.
// Request channel (req_*): action, key, slot_id. Add stores a key handle and
// returns its slot id (or the id it already holds); erase frees a slot; get
// reads back the key held in a slot. Response channel (rsp_*): result_id,
// result_key, status and the number of occupied slots after the beat.
// Each request beat gives exactly one response beat, in order.
// A request accepted is held in the request register; the slot table then
// works on it and its result is registered into the response register.
// Throughput: one beat per cycle while rsp_ready is high; the key match,
// the free stack pop or push and the slot update all complete in the single
// stage between the request register and the response register.
// Stall: while rsp_ready is low the response holds; one more request is
// taken into the request register and then req_ready drops.
// Reset (synchronous, active high): all slots empty, free stack full with
// id 0 on top, both channels empty. No clearing pass is needed.

module handle_slot_allocator_top #(
   parameter int SLOTS    = 64,
   parameter int KEY_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [hsa_pkg::ACTION_W-1:0]  req_action,
   input  logic [hsa_pkg::KEY_W-1:0]     req_key,
   input  logic [hsa_pkg::SID_W-1:0]     req_slot_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hsa_pkg::SID_W-1:0]     rsp_result_id,
   output logic [hsa_pkg::KEY_W-1:0]     rsp_result_key,
   output logic [hsa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [hsa_pkg::COUNT_W-1:0]   rsp_count
);

   logic                          req_vld_ff;
   logic                          req_vld_in;
   hsa_pkg::action_type           act_ff;
   logic [hsa_pkg::KEY_W-1:0]     key_ff;
   logic [hsa_pkg::SID_W-1:0]     sid_ff;
   logic                          rsp_vld_ff;
   logic                          rsp_vld_in;
   hsa_pkg::result_type           rsp_ff;
   hsa_pkg::result_type           tbl_result;
   logic                          advance;
   logic                          req_take;

   // move the held request into the response register when it is free
   assign advance   = req_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !req_vld_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign req_vld_in = req_take || (req_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && !rsp_ready);

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         act_ff <= hsa_pkg::action_type'(req_action);
         key_ff <= req_key;
         sid_ff <= req_slot_id;
      end
   end

   // slot table does the work for the held request
   hsa_slot_table #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .exec   (advance),
      .action (act_ff),
      .key    (KEY_BITS'(key_ff)),
      .sid    (sid_ff),
      .result (tbl_result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= tbl_result;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_result_id  = rsp_ff.result_id;
   assign rsp_result_key = rsp_ff.result_key;
   assign rsp_status     = rsp_ff.status;
   assign rsp_count      = rsp_ff.count;

endmodule
